// ===== src/ppn_pkg.sv =====
// Shared constants, types and register codes of the projection profile normalizer.
package ppn_pkg;

	localparam int MAX_DIM   = 64;
	localparam int CNT_W     = $clog2(MAX_DIM + 1);
	localparam int POS_W     = $clog2(MAX_DIM);
	localparam int DIM_W     = 7;
	localparam int PIX_W     = 8;
	localparam int FRAC_W    = 16;
	localparam int VAL_W     = FRAC_W + 1;
	localparam int BIN_OUT_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = DIM_W;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);
	localparam int DIV_IDX_W = $clog2(FRAC_W);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIRECTION = 2'd0,
		REG_WIDTH     = 2'd1,
		REG_HEIGHT    = 2'd2
	} cfg_reg_t;

	// One classified pixel as it travels from the front end to the back end.
	typedef struct packed {
		logic [POS_W-1:0] bin;
		logic             hit;
		logic             image_end;
		logic [CNT_W-1:0] nbins;
	} ppn_item_t;

endpackage

// ===== src/projection_profile_normalizer.sv =====
// Top level of the projection profile normalizer. Pixels are taken one per cycle while start is
// high and busy is low, and the bin count update follows the pixel transfer through the queue
// and the back end's stage register. Once the last pixel of an image is counted, the values of
// the profile follow one another, paced by the one-bit-per-cycle divider, which is skipped when
// every count is zero; busy rises once the four-entry queue fills. Results cannot be stalled.
// Reset restores the register defaults and marks every bin count as zero.
module projection_profile_normalizer
	import ppn_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [PIX_W-1:0]     pixel,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output logic                 result_valid,
	output logic [VAL_W-1:0]     profile_value,
	output logic [BIN_OUT_W-1:0] bin_index,
	output logic                 last
);

	// A pixel transfer happens whenever start is high and the queue has room.
	logic      accept;
	logic      queue_full;
	ppn_item_t front_item;
	logic      head_valid;
	ppn_item_t head_item;
	logic      pop;

	assign busy   = queue_full;
	assign accept = start && !queue_full;

	// The front end holds the configuration and the row and column position, and turns each
	// pixel into a bin number, a hit flag and an end-of-image mark with the bin count to emit.
	ppn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.pixel    (pixel),
		.item     (front_item)
	);

	// The queue lets the front end keep taking pixels while the back end is busy normalizing.
	ppn_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_item (front_item),
		.pop       (pop),
		.head_valid(head_valid),
		.head_item (head_item),
		.full      (queue_full)
	);

	// The back end updates the bin memory with a read-modify-write and a bypass for back to
	// back hits on one bin, then walks the bins and divides each by the largest count.
	ppn_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_item    (head_item),
		.pop          (pop),
		.result_valid (result_valid),
		.profile_value(profile_value),
		.bin_index    (bin_index),
		.last         (last)
	);

endmodule

// ===== src/ppn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ppn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/ppn_front.sv =====
// Front end: configuration registers, image position tracking and pixel classification.
module ppn_front
	import ppn_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 accept,
	input  logic [PIX_W-1:0]     pixel,
	output ppn_item_t            item
);

	logic             direction_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] row_q;

	logic [CNT_W-1:0] w_eff;
	logic [CNT_W-1:0] h_eff;
	logic             row_end;
	logic             image_end;

	// Zero is taken as one and anything above the largest size as the largest size.
	function automatic logic [CNT_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (int'(v) > MAX_DIM) begin
			r = CNT_W'(MAX_DIM);
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

	assign w_eff     = clamp_dim(width_q);
	assign h_eff     = clamp_dim(height_q);
	assign row_end   = (CNT_W'(col_q) + CNT_W'(1)) >= w_eff;
	assign image_end = row_end && ((CNT_W'(row_q) + CNT_W'(1)) >= h_eff);

	assign item.bin       = direction_q ? row_q : col_q;
	assign item.hit       = (pixel != '0);
	assign item.image_end = image_end;
	assign item.nbins     = direction_q ? h_eff : w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
			width_q     <= DIM_W'(64);
			height_q    <= DIM_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DIRECTION: direction_q <= cfg_data[0];
				REG_WIDTH:     width_q     <= cfg_data;
				REG_HEIGHT:    height_q    <= cfg_data;
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (image_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + POS_W'(1);
			end else begin
				col_q <= col_q + POS_W'(1);
			end
		end
	end

endmodule

// ===== src/ppn_queue.sv =====
// Short queue of classified pixels between the front end and the back end.
module ppn_queue
	import ppn_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  ppn_item_t push_item,
	input  logic      pop,
	output logic      head_valid,
	output ppn_item_t head_item,
	output logic      full
);

	ppn_item_t         entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];
	assign full       = (count_q == QCNT_W'(QDEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> !pop) else $error("queue read while empty");

endmodule

// ===== src/ppn_back.sv =====
// Back end: bin count memory update, largest count tracking and the normalization pass.
module ppn_back
	import ppn_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  ppn_item_t            head_item,
	output logic                 pop,
	output logic                 result_valid,
	output logic [VAL_W-1:0]     profile_value,
	output logic [BIN_OUT_W-1:0] bin_index,
	output logic                 last
);

	typedef enum logic [2:0] {
		ST_RUN,
		ST_RD,
		ST_LD,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t               state_q;
	logic                 s1_valid_q;
	ppn_item_t            s1_item_q;
	logic                 fwd_valid_q;
	logic [POS_W-1:0]     fwd_addr_q;
	logic [CNT_W-1:0]     fwd_data_q;
	logic [MAX_DIM-1:0]   bin_valid_q;
	logic [CNT_W-1:0]     largest_q;
	logic [CNT_W-1:0]     nbins_q;
	logic [POS_W-1:0]     k_q;
	logic [CNT_W-1:0]     rem_q;
	logic [VAL_W-1:0]     quo_q;
	logic [DIV_IDX_W-1:0] bit_q;
	logic                 result_valid_q;
	logic [VAL_W-1:0]     profile_value_q;
	logic [BIN_OUT_W-1:0] bin_index_q;
	logic                 last_q;

	logic                 ram_we;
	logic [POS_W-1:0]     ram_raddr;
	logic [CNT_W-1:0]     ram_rdata;
	logic [CNT_W-1:0]     cur_count;
	logic [CNT_W-1:0]     new_count;
	logic [CNT_W-1:0]     emit_count;
	logic [FRAC_W-1:0]    half_largest;
	logic [CNT_W:0]       div_shift;
	logic                 div_fits;
	logic                 emit_last;

	ppn_ram #(
		.WIDTH(CNT_W),
		.DEPTH(MAX_DIM)
	) u_bins (
		.clk  (clk),
		.we   (ram_we),
		.waddr(s1_item_q.bin),
		.wdata(new_count),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign pop       = (state_q == ST_RUN) && head_valid && !(s1_valid_q && s1_item_q.image_end);
	assign ram_raddr = (state_q == ST_RUN) ? head_item.bin : k_q;

	// The previous cycle's write is not yet in the read data; take it from the bypass.
	always_comb begin
		if (fwd_valid_q && (fwd_addr_q == s1_item_q.bin)) begin
			cur_count = fwd_data_q;
		end else if (bin_valid_q[s1_item_q.bin]) begin
			cur_count = ram_rdata;
		end else begin
			cur_count = '0;
		end
	end

	assign new_count    = (cur_count == CNT_W'(MAX_DIM)) ? cur_count : cur_count + CNT_W'(1);
	assign ram_we       = s1_valid_q && s1_item_q.hit;
	assign emit_count   = bin_valid_q[k_q] ? ram_rdata : '0;
	assign half_largest = FRAC_W'(largest_q >> 1);
	assign div_shift    = {rem_q, half_largest[bit_q]};
	assign div_fits     = div_shift >= {1'b0, largest_q};
	assign emit_last    = (CNT_W'(k_q) + CNT_W'(1)) == nbins_q;

	assign result_valid  = result_valid_q;
	assign profile_value = profile_value_q;
	assign bin_index     = bin_index_q;
	assign last          = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s1_item_q   <= '0;
			fwd_valid_q <= 1'b0;
			fwd_addr_q  <= '0;
			fwd_data_q  <= '0;
		end else begin
			s1_valid_q  <= pop;
			if (pop) begin
				s1_item_q <= head_item;
			end
			fwd_valid_q <= ram_we;
			fwd_addr_q  <= s1_item_q.bin;
			fwd_data_q  <= new_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_RUN;
			bin_valid_q     <= '0;
			largest_q       <= '0;
			nbins_q         <= '0;
			k_q             <= '0;
			rem_q           <= '0;
			quo_q           <= '0;
			bit_q           <= '0;
			result_valid_q  <= 1'b0;
			profile_value_q <= '0;
			bin_index_q     <= '0;
			last_q          <= 1'b0;
		end else begin
			result_valid_q <= (state_q == ST_OUT);
			if (ram_we) begin
				bin_valid_q[s1_item_q.bin] <= 1'b1;
				if (new_count > largest_q) begin
					largest_q <= new_count;
				end
			end
			unique case (state_q)
				ST_RUN: begin
					if (s1_valid_q && s1_item_q.image_end) begin
						nbins_q <= s1_item_q.nbins;
						k_q     <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_LD;
				end
				ST_LD: begin
					if (largest_q == '0) begin
						quo_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						// Integer bit of the quotient; a count never exceeds the largest.
						if (emit_count >= largest_q) begin
							rem_q <= emit_count - largest_q;
							quo_q <= VAL_W'(1);
						end else begin
							rem_q <= emit_count;
							quo_q <= '0;
						end
						bit_q   <= DIV_IDX_W'(FRAC_W - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_fits) begin
						rem_q <= CNT_W'(div_shift - {1'b0, largest_q});
					end else begin
						rem_q <= CNT_W'(div_shift);
					end
					quo_q <= {quo_q[VAL_W-2:0], div_fits};
					if (bit_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						bit_q <= bit_q - DIV_IDX_W'(1);
					end
				end
				ST_OUT: begin
					profile_value_q <= quo_q;
					bin_index_q     <= BIN_OUT_W'(k_q);
					last_q          <= emit_last;
					if (emit_last) begin
						bin_valid_q <= '0;
						largest_q   <= '0;
						state_q     <= ST_RUN;
					end else begin
						k_q     <= k_q + POS_W'(1);
						state_q <= ST_RD;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	a_result_from_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == ST_OUT)) else $error("result outside output state");

	a_hold_queue_at_image_end: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && s1_item_q.image_end) |-> !pop) else $error("pixel taken past image end");

	a_largest_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		largest_q <= CNT_W'(MAX_DIM)) else $error("largest count out of range");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < largest_q)) else $error("divider remainder too large");

endmodule
